>>> design/assert_macros.svh
// Assertion macros used by the top-level RTL file of the table engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> design/ate_pkg.sv
// Package of shared types for the table engine.
`default_nettype none
package ate_pkg;

   typedef enum logic [2:0] {
      CMD_CLEAR   = 3'd0,
      CMD_INSERT  = 3'd1,
      CMD_DELETE  = 3'd2,
      CMD_READ    = 3'd3,
      CMD_LSEARCH = 3'd4,
      CMD_SORT    = 3'd5,
      CMD_BSEARCH = 3'd6,
      CMD_NOP     = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_FULL      = 2'd1,
      STS_RANGE     = 2'd2,
      STS_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_LATCH,
      DP_CLEAR,
      DP_SET_FULL,
      DP_SET_RANGE,
      DP_INS_INIT,
      DP_INS_RD,
      DP_INS_MOVE,
      DP_INS_PUT,
      DP_DEL_INIT,
      DP_DEL_RD,
      DP_DEL_MOVE,
      DP_DEL_DONE,
      DP_RD_ISSUE,
      DP_RD_TAKE,
      DP_LIN_INIT,
      DP_LIN_RD,
      DP_LIN_HIT,
      DP_NEXT_I,
      DP_SRT_INIT,
      DP_SRT_RD,
      DP_SRT_HEAD,
      DP_SCAN_RD,
      DP_SCAN_STEP,
      DP_SWAP_A,
      DP_SWAP_B,
      DP_BS_INIT,
      DP_BS_RD,
      DP_BS_HIT,
      DP_BS_UP,
      DP_BS_DOWN
   } dp_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INS_LOOP,
      ST_INS_WR,
      ST_DEL_LOOP,
      ST_DEL_WR,
      ST_RD_WAIT,
      ST_LIN_LOOP,
      ST_LIN_CMP,
      ST_SRT_OUTER,
      ST_SRT_HEAD,
      ST_SCAN_LOOP,
      ST_SCAN_CMP,
      ST_SWAP,
      ST_BS_LOOP,
      ST_BS_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    pos_gt_cnt;
      logic    pos_ge_cnt;
      logic    i_gt_pos;
      logic    i_lt_cnt;
      logic    i1_lt_cnt;
      logic    j_lt_cnt;
      logic    eq_key;
      logic    key_gt;
      logic    best_ne_i;
      logic    lo_lt_hi;
   } dp_flags_type;

endpackage
`default_nettype wire

>>> design/array_table_engine_unit.sv
// Top level of the table engine: controller, datapath and checks.
// Clear, no-op and error beats finish straight from dispatch; read, insert, delete, search and
// sort step through controller states, with one table RAM access per compare or move through
// a single registered read port; a binary search sorts the table first.
// Throughput: one beat at a time; busy stays high from acceptance to the result strobe.
// Reset (synchronous, active high) empties the table and returns the controller to idle.
// Results are strobed for one cycle and cannot be held off by the receiver.
`default_nettype none
`include "assert_macros.svh"
module array_table_engine_unit #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [2:0]                    req_command,
   input  wire logic [$clog2(DEPTH)-1:0]      req_position_in,
   input  wire logic signed [DATA_WIDTH-1:0]  req_value_in,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic [$clog2(DEPTH)-1:0]           rsp_position_out,
   output logic signed [DATA_WIDTH-1:0]       rsp_data_out,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_count_out
);
   import ate_pkg::*;

   dp_cmd_type   dp_cmd;
   dp_flags_type dp_flags;
   logic         accept;

   // Accept a beat only while idle; hold everything else off with busy.
   assign accept = start && !busy;

   ate_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .dp_flags   (dp_flags),
      .dp_cmd     (dp_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   ate_datapath #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .dp_cmd           (dp_cmd),
      .dp_flags         (dp_flags),
      .req_command      (req_command),
      .req_position_in  (req_position_in),
      .req_value_in     (req_value_in),
      .rsp_status       (rsp_status),
      .rsp_position_out (rsp_position_out),
      .rsp_data_out     (rsp_data_out),
      .rsp_count_out    (rsp_count_out)
   );

   // Count never passes the table depth.
   `ASSERT_SAME(a_count_bound, clock, reset, 1'b1,
      rsp_count_out <= ($clog2(DEPTH+1))'(DEPTH))
   // A result beat only appears while a command is in flight.
   `ASSERT_SAME(a_strobe_busy, clock, reset, rsp_strobe, busy)
   // After the result beat the engine is free again.
   `ASSERT_NEXT(a_strobe_free, clock, reset, rsp_strobe, !busy && !rsp_strobe)
   // An accepted beat never yields its result in the next cycle.
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy && !rsp_strobe)
endmodule
`default_nettype wire

>>> design/ate_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ate_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end
endmodule
`default_nettype wire

>>> design/ate_datapath.sv
// Datapath of the table engine: indices, count, result registers and table RAM.
`default_nettype none
module ate_datapath #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ate_pkg::dp_cmd_type           dp_cmd,
   output ate_pkg::dp_flags_type              dp_flags,
   input  wire logic [2:0]                    req_command,
   input  wire logic [$clog2(DEPTH)-1:0]      req_position_in,
   input  wire logic signed [DATA_WIDTH-1:0]  req_value_in,
   output logic [1:0]                         rsp_status,
   output logic [$clog2(DEPTH)-1:0]           rsp_position_out,
   output logic signed [DATA_WIDTH-1:0]       rsp_data_out,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_count_out
);
   import ate_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type                 cmd_ff, cmd_in;
   logic [IDX_W-1:0]        pos_ff, pos_in;
   logic signed [DATA_WIDTH-1:0] key_ff, key_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        i_ff, i_in;
   logic [CNT_W-1:0]        j_ff, j_in;
   logic [IDX_W-1:0]        best_ff, best_in;
   logic signed [DATA_WIDTH-1:0] bestv_ff, bestv_in;
   logic signed [DATA_WIDTH-1:0] hold_ff, hold_in;
   logic [CNT_W-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]        hi1_ff, hi1_in;
   status_type              status_ff, status_in;
   logic [IDX_W-1:0]        posout_ff, posout_in;
   logic signed [DATA_WIDTH-1:0] data_ff, data_in;

   logic                    we;
   logic [IDX_W-1:0]        waddr, raddr;
   logic [DATA_WIDTH-1:0]   wdata, rdata_raw;
   logic signed [DATA_WIDTH-1:0] rdata;
   logic [CNT_W:0]          mid_sum;
   logic [IDX_W-1:0]        mid;
   logic [CNT_W-1:0]        i_m1;

   ate_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock    (clock),
      .we       (we),
      .waddr    (waddr),
      .wdata    (wdata),
      .raddr    (raddr),
      .rdata_ff (rdata_raw)
   );

   assign rdata   = $signed(rdata_raw);
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi1_ff} - (CNT_W+1)'(1);
   assign mid     = mid_sum[IDX_W:1];
   assign i_m1    = i_ff - CNT_W'(1);

   always_comb begin
      dp_flags.cmd        = cmd_ff;
      dp_flags.full       = (count_ff == CNT_W'(DEPTH));
      dp_flags.pos_gt_cnt = (CNT_W'(pos_ff) > count_ff);
      dp_flags.pos_ge_cnt = (CNT_W'(pos_ff) >= count_ff);
      dp_flags.i_gt_pos   = (i_ff > CNT_W'(pos_ff));
      dp_flags.i_lt_cnt   = (i_ff < count_ff);
      dp_flags.i1_lt_cnt  = (({1'b0, i_ff} + (CNT_W+1)'(1)) < {1'b0, count_ff});
      dp_flags.j_lt_cnt   = (j_ff < count_ff);
      dp_flags.eq_key     = (rdata == key_ff);
      dp_flags.key_gt     = (key_ff > rdata);
      dp_flags.best_ne_i  = (best_ff != i_ff[IDX_W-1:0]);
      dp_flags.lo_lt_hi   = (lo_ff < hi1_ff);
   end

   always_comb begin
      cmd_in    = cmd_ff;
      pos_in    = pos_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      best_in   = best_ff;
      bestv_in  = bestv_ff;
      hold_in   = hold_ff;
      lo_in     = lo_ff;
      hi1_in    = hi1_ff;
      status_in = status_ff;
      posout_in = posout_ff;
      data_in   = data_ff;
      we        = 1'b0;
      waddr     = '0;
      wdata     = '0;
      raddr     = '0;
      case (dp_cmd.op)
         DP_LATCH: begin
            cmd_in    = cmd_type'(req_command);
            pos_in    = req_position_in;
            key_in    = req_value_in;
            status_in = STS_OK;
            posout_in = '0;
            data_in   = '0;
         end
         DP_CLEAR:     count_in = '0;
         DP_SET_FULL:  status_in = STS_FULL;
         DP_SET_RANGE: status_in = STS_RANGE;
         DP_INS_INIT:  i_in = count_ff;
         DP_INS_RD:    raddr = i_m1[IDX_W-1:0];
         DP_INS_MOVE: begin
            we    = 1'b1;
            waddr = i_ff[IDX_W-1:0];
            wdata = rdata;
            i_in  = i_m1;
         end
         DP_INS_PUT: begin
            we       = 1'b1;
            waddr    = pos_ff;
            wdata    = key_ff;
            count_in = count_ff + CNT_W'(1);
         end
         DP_DEL_INIT: i_in = CNT_W'(pos_ff) + CNT_W'(1);
         DP_DEL_RD:   raddr = i_ff[IDX_W-1:0];
         DP_DEL_MOVE: begin
            we    = 1'b1;
            waddr = i_m1[IDX_W-1:0];
            wdata = rdata;
            i_in  = i_ff + CNT_W'(1);
         end
         DP_DEL_DONE: count_in = count_ff - CNT_W'(1);
         DP_RD_ISSUE: raddr = pos_ff;
         DP_RD_TAKE:  data_in = rdata;
         DP_LIN_INIT: begin
            i_in      = '0;
            status_in = STS_NOT_FOUND;
         end
         DP_LIN_RD: raddr = i_ff[IDX_W-1:0];
         DP_LIN_HIT: begin
            status_in = STS_OK;
            posout_in = i_ff[IDX_W-1:0];
         end
         DP_NEXT_I:   i_in = i_ff + CNT_W'(1);
         DP_SRT_INIT: i_in = '0;
         DP_SRT_RD:   raddr = i_ff[IDX_W-1:0];
         DP_SRT_HEAD: begin
            hold_in  = rdata;
            bestv_in = rdata;
            best_in  = i_ff[IDX_W-1:0];
            j_in     = i_ff + CNT_W'(1);
         end
         DP_SCAN_RD: raddr = j_ff[IDX_W-1:0];
         DP_SCAN_STEP: begin
            if (rdata < bestv_ff) begin
               bestv_in = rdata;
               best_in  = j_ff[IDX_W-1:0];
            end
            j_in = j_ff + CNT_W'(1);
         end
         DP_SWAP_A: begin
            we    = 1'b1;
            waddr = i_ff[IDX_W-1:0];
            wdata = bestv_ff;
         end
         DP_SWAP_B: begin
            we    = 1'b1;
            waddr = best_ff;
            wdata = hold_ff;
            i_in  = i_ff + CNT_W'(1);
         end
         DP_BS_INIT: begin
            lo_in     = '0;
            hi1_in    = count_ff;
            status_in = STS_NOT_FOUND;
         end
         DP_BS_RD: raddr = mid;
         DP_BS_HIT: begin
            status_in = STS_OK;
            posout_in = mid;
         end
         DP_BS_UP:   lo_in  = CNT_W'(mid) + CNT_W'(1);
         DP_BS_DOWN: hi1_in = CNT_W'(mid);
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      cmd_ff    <= cmd_in;
      pos_ff    <= pos_in;
      key_ff    <= key_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      best_ff   <= best_in;
      bestv_ff  <= bestv_in;
      hold_ff   <= hold_in;
      lo_ff     <= lo_in;
      hi1_ff    <= hi1_in;
      status_ff <= status_in;
      posout_ff <= posout_in;
      data_ff   <= data_in;
   end

   assign rsp_status       = status_ff;
   assign rsp_position_out = posout_ff;
   assign rsp_data_out     = data_ff;
   assign rsp_count_out    = count_ff;
endmodule
`default_nettype wire

>>> design/ate_controller.sv
// Controller state machine of the table engine.
`default_nettype none
module ate_controller (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire ate_pkg::dp_flags_type dp_flags,
   output ate_pkg::dp_cmd_type        dp_cmd,
   output logic                       busy,
   output logic                       rsp_strobe
);
   import ate_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      dp_cmd.op  = DP_NOP;
      busy       = (state_ff != ST_IDLE);
      rsp_strobe = (state_ff == ST_DONE);
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dp_cmd.op = DP_LATCH;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_DONE;
            case (dp_flags.cmd)
               CMD_CLEAR: dp_cmd.op = DP_CLEAR;
               CMD_INSERT: begin
                  if (dp_flags.full) begin
                     dp_cmd.op = DP_SET_FULL;
                  end else if (dp_flags.pos_gt_cnt) begin
                     dp_cmd.op = DP_SET_RANGE;
                  end else begin
                     dp_cmd.op = DP_INS_INIT;
                     state_in  = ST_INS_LOOP;
                  end
               end
               CMD_DELETE: begin
                  if (dp_flags.pos_ge_cnt) begin
                     dp_cmd.op = DP_SET_RANGE;
                  end else begin
                     dp_cmd.op = DP_DEL_INIT;
                     state_in  = ST_DEL_LOOP;
                  end
               end
               CMD_READ: begin
                  if (dp_flags.pos_ge_cnt) begin
                     dp_cmd.op = DP_SET_RANGE;
                  end else begin
                     dp_cmd.op = DP_RD_ISSUE;
                     state_in  = ST_RD_WAIT;
                  end
               end
               CMD_LSEARCH: begin
                  dp_cmd.op = DP_LIN_INIT;
                  state_in  = ST_LIN_LOOP;
               end
               CMD_SORT, CMD_BSEARCH: begin
                  dp_cmd.op = DP_SRT_INIT;
                  state_in  = ST_SRT_OUTER;
               end
               default: dp_cmd.op = DP_NOP;
            endcase
         end
         ST_INS_LOOP: begin
            if (dp_flags.i_gt_pos) begin
               dp_cmd.op = DP_INS_RD;
               state_in  = ST_INS_WR;
            end else begin
               dp_cmd.op = DP_INS_PUT;
               state_in  = ST_DONE;
            end
         end
         ST_INS_WR: begin
            dp_cmd.op = DP_INS_MOVE;
            state_in  = ST_INS_LOOP;
         end
         ST_DEL_LOOP: begin
            if (dp_flags.i_lt_cnt) begin
               dp_cmd.op = DP_DEL_RD;
               state_in  = ST_DEL_WR;
            end else begin
               dp_cmd.op = DP_DEL_DONE;
               state_in  = ST_DONE;
            end
         end
         ST_DEL_WR: begin
            dp_cmd.op = DP_DEL_MOVE;
            state_in  = ST_DEL_LOOP;
         end
         ST_RD_WAIT: begin
            dp_cmd.op = DP_RD_TAKE;
            state_in  = ST_DONE;
         end
         ST_LIN_LOOP: begin
            if (dp_flags.i_lt_cnt) begin
               dp_cmd.op = DP_LIN_RD;
               state_in  = ST_LIN_CMP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_LIN_CMP: begin
            if (dp_flags.eq_key) begin
               dp_cmd.op = DP_LIN_HIT;
               state_in  = ST_DONE;
            end else begin
               dp_cmd.op = DP_NEXT_I;
               state_in  = ST_LIN_LOOP;
            end
         end
         ST_SRT_OUTER: begin
            if (dp_flags.i1_lt_cnt) begin
               dp_cmd.op = DP_SRT_RD;
               state_in  = ST_SRT_HEAD;
            end else if (dp_flags.cmd == CMD_SORT) begin
               state_in = ST_DONE;
            end else begin
               dp_cmd.op = DP_BS_INIT;
               state_in  = ST_BS_LOOP;
            end
         end
         ST_SRT_HEAD: begin
            dp_cmd.op = DP_SRT_HEAD;
            state_in  = ST_SCAN_LOOP;
         end
         ST_SCAN_LOOP: begin
            if (dp_flags.j_lt_cnt) begin
               dp_cmd.op = DP_SCAN_RD;
               state_in  = ST_SCAN_CMP;
            end else if (dp_flags.best_ne_i) begin
               dp_cmd.op = DP_SWAP_A;
               state_in  = ST_SWAP;
            end else begin
               dp_cmd.op = DP_NEXT_I;
               state_in  = ST_SRT_OUTER;
            end
         end
         ST_SCAN_CMP: begin
            dp_cmd.op = DP_SCAN_STEP;
            state_in  = ST_SCAN_LOOP;
         end
         ST_SWAP: begin
            dp_cmd.op = DP_SWAP_B;
            state_in  = ST_SRT_OUTER;
         end
         ST_BS_LOOP: begin
            if (dp_flags.lo_lt_hi) begin
               dp_cmd.op = DP_BS_RD;
               state_in  = ST_BS_CMP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_BS_CMP: begin
            if (dp_flags.eq_key) begin
               dp_cmd.op = DP_BS_HIT;
               state_in  = ST_DONE;
            end else if (dp_flags.key_gt) begin
               dp_cmd.op = DP_BS_UP;
               state_in  = ST_BS_LOOP;
            end else begin
               dp_cmd.op = DP_BS_DOWN;
               state_in  = ST_BS_LOOP;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

>>> bench/array_table_engine_unit_tb.sv
// Self-checking bench for the table engine: directed table, a full-table fill, then random command streams.
`timescale 1ns / 100ps
`default_nettype none
module array_table_engine_unit_tb;
   import ate_pkg::*;

   localparam int DEPTH = 64;
   localparam int WATCHDOG_LIMIT = 20000;

   // One row of the directed table; has_exp marks rows whose outcome is typed in.
   typedef struct {
      cmd_type           cmd;
      logic [5:0]        pos;
      logic signed [31:0] val;
      logic              has_exp;
      status_type        e_status;
      logic [5:0]        e_pos;
      logic signed [31:0] e_data;
      logic [6:0]        e_count;
   } stim_row_type;

   typedef struct {
      status_type        status;
      logic [5:0]        pos;
      logic signed [31:0] data;
      logic [6:0]        count;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_command = '0;
   logic [5:0] req_position_in = '0;
   logic signed [31:0] req_value_in = '0;
   logic rsp_strobe;
   logic [1:0] rsp_status;
   logic [5:0] rsp_position_out;
   logic signed [31:0] rsp_data_out;
   logic [6:0] rsp_count_out;

   // Shadow copy of the table held by the predictor.
   logic signed [31:0] shadow_table [DEPTH];
   int unsigned shadow_count;

   outcome_type pending_outcomes [$];
   int unsigned mismatch_count;
   int unsigned beats_sent;
   int unsigned results_seen = 0;
   int unsigned idle_cycles;
   bit quiet_phase;

   always #6 clock = ~clock;

   array_table_engine_unit #(.DEPTH(DEPTH), .DATA_WIDTH(32)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_position_in(req_position_in),
      .req_value_in(req_value_in), .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_position_out(rsp_position_out), .rsp_data_out(rsp_data_out),
      .rsp_count_out(rsp_count_out)
   );

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d (beat %0d)", what, got, want, results_seen);
      mismatch_count++;
   endtask

   // Selection sort, ascending on signed values, as the engine does it.
   function automatic void sort_shadow();
      int unsigned best;
      logic signed [31:0] tmp;
      for (int unsigned i = 0; i + 1 < shadow_count; i++) begin
         best = i;
         for (int unsigned j = i + 1; j < shadow_count; j++)
            if (shadow_table[j] < shadow_table[best]) best = j;
         tmp = shadow_table[i];
         shadow_table[i] = shadow_table[best];
         shadow_table[best] = tmp;
      end
   endfunction

   // Advance the shadow table by one command and return its outcome.
   function automatic outcome_type apply_command(cmd_type cmd, logic [5:0] pos,
                                                 logic signed [31:0] val);
      outcome_type o;
      int lo;
      int hi;
      int mid;
      o.status = STS_OK;
      o.pos = '0;
      o.data = '0;
      case (cmd)
         CMD_CLEAR: shadow_count = 0;
         CMD_INSERT: begin
            if (shadow_count >= DEPTH) o.status = STS_FULL;
            else if (pos > shadow_count) o.status = STS_RANGE;
            else begin
               for (int unsigned i = shadow_count; i > pos; i--)
                  shadow_table[i] = shadow_table[i-1];
               shadow_table[pos] = val;
               shadow_count++;
            end
         end
         CMD_DELETE: begin
            if (pos >= shadow_count) o.status = STS_RANGE;
            else begin
               for (int unsigned i = pos + 1; i < shadow_count; i++)
                  shadow_table[i-1] = shadow_table[i];
               shadow_count--;
            end
         end
         CMD_READ: begin
            if (pos >= shadow_count) o.status = STS_RANGE;
            else o.data = shadow_table[pos];
         end
         CMD_LSEARCH: begin
            o.status = STS_NOT_FOUND;
            for (int unsigned i = 0; i < shadow_count; i++)
               if (shadow_table[i] == val) begin
                  o.status = STS_OK;
                  o.pos = 6'(i);
                  break;
               end
         end
         CMD_SORT: sort_shadow();
         CMD_BSEARCH: begin
            sort_shadow();
            o.status = STS_NOT_FOUND;
            lo = 0;
            hi = int'(shadow_count) - 1;
            while (lo <= hi) begin
               mid = (lo + hi) / 2;
               if (shadow_table[mid] == val) begin
                  o.status = STS_OK;
                  o.pos = 6'(mid);
                  break;
               end else if (val > shadow_table[mid]) lo = mid + 1;
               else hi = mid - 1;
            end
         end
         default: ;
      endcase
      o.count = 7'(shadow_count);
      return o;
   endfunction

   // Present one beat, hold it until accepted, then drop start unless told to keep it.
   task automatic send_beat(cmd_type cmd, logic [5:0] pos, logic signed [31:0] val,
                            bit keep_start);
      start <= 1'b1;
      req_command <= cmd;
      req_position_in <= pos;
      req_value_in <= val;
      do @(posedge clock); while (busy);
      beats_sent++;
      if (!keep_start) start <= 1'b0;
   endtask

   // Compare every strobed result with the oldest outcome waiting.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         results_seen <= results_seen + 1;
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected result beat, status", rsp_status, 0);
         end else begin
            outcome_type e;
            e = pending_outcomes.pop_front();
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_position_out !== e.pos)
               report_mismatch("position", rsp_position_out, e.pos);
            if (rsp_data_out !== e.data) report_mismatch("data", rsp_data_out, e.data);
            if (rsp_count_out !== e.count) report_mismatch("count", rsp_count_out, e.count);
         end
      end
   end

   // Watchdog: count cycles with no beat in either direction.
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results pending", pending_outcomes.size());
         $display("tb: failure");
         $finish;
      end
   end

   // Random gap on the sender side with start dropped; none in the quiet phase near the end.
   task automatic maybe_gap();
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Issue one beat: predict its outcome, queue it, then send.
   task automatic issue(cmd_type cmd, logic [5:0] pos, logic signed [31:0] val);
      outcome_type o;
      o = apply_command(cmd, pos, val);
      pending_outcomes.push_back(o);
      maybe_gap();
      send_beat(cmd, pos, val, 1'b1);
   endtask

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 4))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return $signed($urandom_range(0, 15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   stim_row_type directed_rows [$];

   initial begin
      stim_row_type r;
      outcome_type o;
      cmd_type cmd;
      logic [5:0] pos;
      logic signed [31:0] val;
      int unsigned pick;

      mismatch_count = 0;
      beats_sent = 0;
      quiet_phase = 0;
      shadow_count = 0;

      // Directed table: empty-table errors, extremes, duplicates, every command.
      directed_rows = '{
         '{CMD_READ,    6'd0,  32'sd0,        1'b1, STS_RANGE,     6'd0, 32'sd0, 7'd0},
         '{CMD_DELETE,  6'd0,  32'sd0,        1'b1, STS_RANGE,     6'd0, 32'sd0, 7'd0},
         '{CMD_LSEARCH, 6'd0,  32'sd5,        1'b1, STS_NOT_FOUND, 6'd0, 32'sd0, 7'd0},
         '{CMD_BSEARCH, 6'd0,  32'sd5,        1'b1, STS_NOT_FOUND, 6'd0, 32'sd0, 7'd0},
         '{CMD_SORT,    6'd0,  32'sd0,        1'b1, STS_OK,        6'd0, 32'sd0, 7'd0},
         '{CMD_INSERT,  6'd1,  32'sd1,        1'b1, STS_RANGE,     6'd0, 32'sd0, 7'd0},
         '{CMD_INSERT,  6'd0,  32'sh7fffffff, 1'b1, STS_OK,        6'd0, 32'sd0, 7'd1},
         '{CMD_INSERT,  6'd1,  32'sh80000000, 1'b1, STS_OK,        6'd0, 32'sd0, 7'd2},
         '{CMD_READ,    6'd1,  32'sd0,        1'b1, STS_OK, 6'd0, 32'sh80000000, 7'd2},
         '{CMD_INSERT,  6'd0,  32'sd7,        1'b0, STS_OK,        6'd0, 32'sd0, 7'd0},
         '{CMD_INSERT,  6'd2,  32'sd7,        1'b0, STS_OK,        6'd0, 32'sd0, 7'd0},
         '{CMD_INSERT,  6'd63, 32'sd3,        1'b1, STS_RANGE,     6'd0, 32'sd0, 7'd4},
         '{CMD_LSEARCH, 6'd0,  32'sd7,        1'b0, STS_OK,        6'd0, 32'sd0, 7'd0},
         '{CMD_LSEARCH, 6'd0,  -32'sd1,       1'b0, STS_OK,        6'd0, 32'sd0, 7'd0},
         '{CMD_BSEARCH, 6'd0,  32'sd7,        1'b0, STS_OK,        6'd0, 32'sd0, 7'd0},
         '{CMD_BSEARCH, 6'd0,  32'sh80000000, 1'b0, STS_OK,        6'd0, 32'sd0, 7'd0},
         '{CMD_READ,    6'd3,  32'sd0,        1'b0, STS_OK,        6'd0, 32'sd0, 7'd0},
         '{CMD_DELETE,  6'd0,  32'sd0,        1'b0, STS_OK,        6'd0, 32'sd0, 7'd0},
         '{CMD_DELETE,  6'd2,  32'sd0,        1'b0, STS_OK,        6'd0, 32'sd0, 7'd0},
         '{CMD_NOP,     6'd63, -32'sd1,       1'b1, STS_OK,        6'd0, 32'sd0, 7'd2},
         '{CMD_CLEAR,   6'd5,  32'sd9,        1'b1, STS_OK,        6'd0, 32'sd0, 7'd0},
         '{CMD_READ,    6'd0,  32'sd0,        1'b1, STS_RANGE,     6'd0, 32'sd0, 7'd0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[k]) begin
         r = directed_rows[k];
         o = apply_command(r.cmd, r.pos, r.val);
         if (r.has_exp && (o.status !== r.e_status || o.data !== r.e_data ||
                           o.count !== r.e_count || o.pos !== r.e_pos)) begin
            report_mismatch("directed row typed outcome", k, k);
         end
         if (r.has_exp) begin
            o.status = r.e_status;
            o.pos = r.e_pos;
            o.data = r.e_data;
            o.count = r.e_count;
         end
         pending_outcomes.push_back(o);
         maybe_gap();
         send_beat(r.cmd, r.pos, r.val, 1'b1);
      end

      // Fill to the top and try again: the full-table error, then a read, a search and a delete.
      for (int i = 0; i < DEPTH; i++)
         issue(CMD_INSERT, 6'($urandom_range(0, shadow_count)), random_value());
      issue(CMD_INSERT, 6'($urandom_range(0, 63)), random_value());
      issue(CMD_INSERT, 6'd0, 32'sd1);
      issue(CMD_READ, 6'd63, 32'sd0);
      issue(CMD_BSEARCH, 6'd0, shadow_table[$urandom_range(0, DEPTH-1)]);
      issue(CMD_DELETE, 6'd63, 32'sd0);

      // Hold off until every outstanding result has been seen.
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);

      // Random part: mostly in-range commands, keeping the table short so sorts stay cheap.
      for (int n = 0; n < 1200; n++) begin
         if (n >= 1100) quiet_phase = 1;
         pick = $urandom_range(0, 99);
         pos = (shadow_count == 0 || $urandom_range(0, 9) == 0) ?
               6'($urandom) : 6'($urandom_range(0, shadow_count));
         val = random_value();
         if ($urandom_range(0, 1) && shadow_count != 0)
            val = shadow_table[$urandom_range(0, shadow_count - 1)];
         if (pick < 35 && shadow_count < 24) cmd = CMD_INSERT;
         else if (pick < 55) cmd = CMD_DELETE;
         else if (pick < 70) cmd = CMD_READ;
         else if (pick < 82) cmd = CMD_LSEARCH;
         else if (pick < 90) cmd = CMD_BSEARCH;
         else if (pick < 95) cmd = CMD_SORT;
         else if (pick < 98) cmd = CMD_CLEAR;
         else cmd = CMD_NOP;
         issue(cmd, pos, val);
      end

      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("run: %0d beats sent, %0d results checked, incl. full, range and miss cases",
               beats_sent, results_seen);
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
`default_nettype wire
